// File: design/psu_pkg.sv
// shared types, sizes and helpers for the particle swarm update block
// no dependencies
package psu_pkg;

    localparam int NUM_PARTICLES = 64;
    localparam int DIMS          = 8;
    localparam int MAX_REPORT    = 8;
    localparam int NREP          = (DIMS < MAX_REPORT) ? DIMS : MAX_REPORT;
    localparam int ADDR_W        = $clog2(NUM_PARTICLES * DIMS);
    localparam int D_W           = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int PART_W        = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;

    // register indexes
    localparam logic [2:0] REG_INERTIA  = 3'd0;
    localparam logic [2:0] REG_COG_GAIN = 3'd1;
    localparam logic [2:0] REG_SOC_GAIN = 3'd2;
    localparam logic [2:0] REG_DT       = 3'd3;
    localparam logic [2:0] REG_INV_DT   = 3'd4;
    localparam logic [2:0] REG_TOL      = 3'd5;

    // request modes
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_FITNESS = 2'd1;
    localparam logic [1:0] MODE_STEP    = 2'd2;

    // result kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_COORD  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISP, ST_LOAD, ST_FCHK, ST_CRD, ST_CWR, ST_RPT,
        ST_G1, ST_G2, ST_SRD, ST_SMUL, ST_SSUM, ST_SPOS, ST_SWR
    } t_state;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
        logic pos_en;
    } t_step_ctl;

    // saturate to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
        logic signed [31:0] y;
        if (x > 48'sd2147483647)
            y = 32'sh7fffffff;
        else if (x < -48'sd2147483648)
            y = 32'sh80000000;
        else
            y = x[31:0];
        return y;
    endfunction

endpackage

// File: design/particle_swarm_update.sv
// particle swarm update top level: config port, sequencer and state memories
// depends on psu_pkg and psu_step_dp
//
// channel   direction  handshake                   payload
// request   in         start & !busy               i_mode .. i_rand_two
// result    out        o_result_valid, one cycle   o_kind .. o_last
// config    in         psel & penable & pwrite     paddr, pwdata (prdata on read)
//
// load: writes one coordinate. fitness: checks the bests, copies a best row when
// one improves, and adds a round report at end of round. step: one coordinate at
// a time, set by the single-port state memories and the shared multiply stages.
// reset clears control, registers and valid bits; the memories hold junk until
// written. results cannot be stalled; a new request is taken once busy falls.
module particle_swarm_update (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_mode,
    input  logic [5:0]           i_particle,
    input  logic [2:0]           i_coord_index,
    input  logic signed [31:0]   i_position_in,
    input  logic signed [31:0]   i_velocity_in,
    input  logic signed [31:0]   i_fitness,
    input  logic                 i_end_of_round,
    input  logic [15:0]          i_rand_one,
    input  logic [15:0]          i_rand_two,
    output logic                 o_result_valid,
    output logic                 o_kind,
    output logic [5:0]           o_particle_out,
    output logic [2:0]           o_coord_out,
    output logic signed [31:0]   o_position_out,
    output logic signed [31:0]   o_round_min,
    output logic [5:0]           o_best_particle,
    output logic                 o_converged,
    output logic                 o_last,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import psu_pkg::*;

    // config registers
    logic [15:0] r_inertia, r_cog, r_soc, r_dt, r_inv_dt;
    logic [30:0] r_tol;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inertia <= 16'd2867;
            r_cog     <= 16'd8192;
            r_soc     <= 16'd8192;
            r_dt      <= 16'd256;
            r_inv_dt  <= 16'd256;
            r_tol     <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                REG_INERTIA:  r_inertia <= pwdata[15:0];
                REG_COG_GAIN: r_cog     <= pwdata[15:0];
                REG_SOC_GAIN: r_soc     <= pwdata[15:0];
                REG_DT:       r_dt      <= pwdata[15:0];
                REG_INV_DT:   r_inv_dt  <= pwdata[15:0];
                REG_TOL:      r_tol     <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[4:2])
            REG_INERTIA:  prdata = {16'd0, r_inertia};
            REG_COG_GAIN: prdata = {16'd0, r_cog};
            REG_SOC_GAIN: prdata = {16'd0, r_soc};
            REG_DT:       prdata = {16'd0, r_dt};
            REG_INV_DT:   prdata = {16'd0, r_inv_dt};
            REG_TOL:      prdata = {1'b0, r_tol};
            default:      prdata = '0;
        endcase
    end

    // request capture
    t_state r_state, n_state;
    logic [1:0]         r_mode;
    logic [5:0]         r_part;
    logic [2:0]         r_coord;
    logic [D_W-1:0]     r_d;
    logic signed [31:0] r_pos_in, r_vel_in, r_fit;
    logic               r_eor;
    logic [15:0]        r_r1, r_r2;
    logic               w_accept;
    logic               w_pok;
    logic               w_last_d;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_pok    = 32'(r_part) < NUM_PARTICLES;
    assign w_last_d = r_d == D_W'(DIMS - 1);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode   <= i_mode;
            r_part   <= i_particle;
            r_coord  <= i_coord_index;
            r_pos_in <= i_position_in;
            r_vel_in <= i_velocity_in;
            r_fit    <= i_fitness;
            r_eor    <= i_end_of_round;
            r_r1     <= i_rand_one;
            r_r2     <= i_rand_two;
        end
    end

    // fitness bookkeeping signals
    logic [NUM_PARTICLES-1:0] r_obv;
    logic               r_cp_own, r_cp_round;
    logic signed [31:0] r_rmin, r_obest;
    logic [5:0]         r_rmin_idx;
    logic               r_rvalid, r_ovalid;
    logic               w_upd_own, w_upd_round;
    logic signed [32:0] w_diff;
    logic [32:0]        w_adiff;
    logic               w_conv;

    // state memories, registered read
    logic signed [31:0] pos_mem [NUM_PARTICLES*DIMS];
    logic signed [31:0] vel_mem [NUM_PARTICLES*DIMS];
    logic signed [31:0] obp_mem [NUM_PARTICLES*DIMS];
    logic signed [31:0] obf_mem [NUM_PARTICLES];
    logic signed [31:0] sb_mem  [DIMS];
    logic [ADDR_W-1:0]  w_addr;
    logic signed [31:0] r_pos_q, r_vel_q, r_obp_q, r_obf_q, r_sb_q;
    logic signed [31:0] w_nv, w_nx;

    assign w_addr = ADDR_W'(PART_W'(r_part)) * ADDR_W'(DIMS) + ADDR_W'(r_d);

    always_ff @(posedge i_clk) begin
        r_pos_q <= pos_mem[w_addr];
        r_vel_q <= vel_mem[w_addr];
        r_obp_q <= obp_mem[w_addr];
        r_obf_q <= obf_mem[PART_W'(r_part)];
        r_sb_q  <= sb_mem[r_d];
        if (r_state == ST_LOAD && w_pok && 32'(r_coord) < DIMS) begin
            pos_mem[w_addr] <= r_pos_in;
            vel_mem[w_addr] <= r_vel_in;
            obp_mem[w_addr] <= r_pos_in;
        end
        if (r_state == ST_SWR) begin
            pos_mem[w_addr] <= w_nx;
            vel_mem[w_addr] <= w_nv;
        end
        if (r_state == ST_CWR && r_cp_own) begin
            obp_mem[w_addr] <= r_pos_q;
        end
        if (r_state == ST_CWR && r_cp_round) begin
            sb_mem[r_d] <= r_pos_q;
        end
        if (r_state == ST_FCHK && w_upd_own) begin
            obf_mem[PART_W'(r_part)] <= r_fit;
        end
    end

    // fitness bookkeeping
    assign w_upd_own   = w_pok && (!r_obv[PART_W'(r_part)] || r_fit < r_obf_q);
    assign w_upd_round = w_pok && (!r_rvalid || r_fit < r_rmin);
    assign w_diff      = $signed({r_obest[31], r_obest}) - $signed({r_rmin[31], r_rmin});
    assign w_adiff     = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
    assign w_conv      = r_ovalid && (w_adiff < {2'b00, r_tol});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obv      <= '0;
            r_rmin     <= '0;
            r_rmin_idx <= '0;
            r_rvalid   <= 1'b0;
            r_obest    <= '0;
            r_ovalid   <= 1'b0;
            r_cp_own   <= 1'b0;
            r_cp_round <= 1'b0;
        end else begin
            if (r_state == ST_LOAD && w_pok && 32'(r_coord) < DIMS) begin
                r_obv[PART_W'(r_part)] <= 1'b0;
            end
            if (r_state == ST_FCHK) begin
                r_cp_own   <= w_upd_own;
                r_cp_round <= w_upd_round;
                if (w_upd_own) begin
                    r_obv[PART_W'(r_part)] <= 1'b1;
                end
                if (w_upd_round) begin
                    r_rmin     <= r_fit;
                    r_rmin_idx <= r_part;
                    r_rvalid   <= 1'b1;
                end
            end
            if (r_state == ST_RPT && r_rvalid) begin
                if (!r_ovalid || w_conv || r_rmin < r_obest) begin
                    r_obest <= r_rmin;
                end
                r_ovalid   <= 1'b1;
                r_rvalid   <= 1'b0;
                r_rmin     <= '0;
                r_rmin_idx <= '0;
            end
        end
    end

    // step gains, Q12.12
    logic [15:0] r_g1, r_g2;
    logic [23:0] r_k1, r_k2;
    logic [31:0] w_cr1, w_cr2, w_gi1, w_gi2;

    assign w_cr1 = 32'(r_cog) * 32'(r_r1);
    assign w_cr2 = 32'(r_soc) * 32'(r_r2);
    assign w_gi1 = 32'(r_g1) * 32'(r_inv_dt);
    assign w_gi2 = 32'(r_g2) * 32'(r_inv_dt);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_G1) begin
            r_g1 <= w_cr1[31:16];
            r_g2 <= w_cr2[31:16];
        end
        if (r_state == ST_G2) begin
            r_k1 <= w_gi1[31:8];
            r_k2 <= w_gi2[31:8];
        end
    end

    t_step_ctl w_ctl;
    assign w_ctl.mul_en = (r_state == ST_SMUL);
    assign w_ctl.sum_en = (r_state == ST_SSUM);
    assign w_ctl.pos_en = (r_state == ST_SPOS);

    psu_step_dp u_dp (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_x       (r_pos_q),
        .i_v       (r_vel_q),
        .i_pb      (r_obp_q),
        .i_gb      (r_sb_q),
        .i_k1      (r_k1),
        .i_k2      (r_k2),
        .i_inertia (r_inertia),
        .i_dt      (r_dt),
        .o_nv      (w_nv),
        .o_nx      (w_nx)
    );

    // sequencer state and coordinate counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_d     <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_d <= (i_mode == MODE_LOAD) ? D_W'(i_coord_index) : '0;
            end else if ((r_state == ST_CWR || r_state == ST_SWR) && !w_last_d) begin
                r_d <= r_d + D_W'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_DISP;
            ST_DISP: begin
                case (r_mode)
                    MODE_LOAD:    n_state = ST_LOAD;
                    MODE_FITNESS: n_state = w_pok ? ST_FCHK : (r_eor ? ST_RPT : ST_IDLE);
                    MODE_STEP:    n_state = w_pok ? ST_G1 : ST_IDLE;
                    default:      n_state = ST_IDLE;
                endcase
            end
            ST_LOAD: n_state = ST_IDLE;
            ST_FCHK: begin
                if (w_upd_own || w_upd_round) n_state = ST_CRD;
                else n_state = r_eor ? ST_RPT : ST_IDLE;
            end
            ST_CRD: n_state = ST_CWR;
            ST_CWR: begin
                if (!w_last_d) n_state = ST_CRD;
                else n_state = r_eor ? ST_RPT : ST_IDLE;
            end
            ST_RPT:  n_state = ST_IDLE;
            ST_G1:   n_state = ST_G2;
            ST_G2:   n_state = ST_SRD;
            ST_SRD:  n_state = ST_SMUL;
            ST_SMUL: n_state = ST_SSUM;
            ST_SSUM: n_state = ST_SPOS;
            ST_SPOS: n_state = ST_SWR;
            ST_SWR:  n_state = w_last_d ? ST_IDLE : ST_SRD;
            default: n_state = ST_IDLE;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= (r_state == ST_RPT) ||
                              (r_state == ST_SWR && 32'(r_d) < NREP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RPT) begin
            o_kind          <= KIND_REPORT;
            o_particle_out  <= '0;
            o_coord_out     <= '0;
            o_position_out  <= '0;
            o_round_min     <= r_rvalid ? r_rmin : '0;
            o_best_particle <= r_rvalid ? r_rmin_idx : '0;
            o_converged     <= r_rvalid && w_conv;
            o_last          <= 1'b1;
        end else if (r_state == ST_SWR) begin
            o_kind          <= KIND_COORD;
            o_particle_out  <= r_part;
            o_coord_out     <= 3'(r_d);
            o_position_out  <= w_nx;
            o_round_min     <= '0;
            o_best_particle <= '0;
            o_converged     <= 1'b0;
            o_last          <= 32'(r_d) == NREP - 1;
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy) else $error("request accepted but block not busy");
    a_report_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_kind == KIND_REPORT) |-> o_last)
        else $error("round report without last");
    a_report_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_kind == KIND_REPORT) |->
        (o_particle_out == '0 && o_position_out == '0))
        else $error("round report carries coordinate fields");
`endif

endmodule

// File: design/psu_step_dp.sv
// per-coordinate velocity and position arithmetic, three registered stages
// depends on psu_pkg
module psu_step_dp (
    input  logic                 i_clk,
    input  psu_pkg::t_step_ctl   i_ctl,
    input  logic signed [31:0]   i_x,
    input  logic signed [31:0]   i_v,
    input  logic signed [31:0]   i_pb,
    input  logic signed [31:0]   i_gb,
    input  logic [23:0]          i_k1,
    input  logic [23:0]          i_k2,
    input  logic [15:0]          i_inertia,
    input  logic [15:0]          i_dt,
    output logic signed [31:0]   o_nv,
    output logic signed [31:0]   o_nx
);
    import psu_pkg::*;

    logic signed [48:0] r_p_in;
    logic signed [57:0] r_p1;
    logic signed [57:0] r_p2;
    logic signed [31:0] r_nv;
    logic signed [48:0] r_vdt;

    logic signed [32:0] w_d1;
    logic signed [32:0] w_d2;
    logic signed [16:0] w_w;
    logic signed [16:0] w_dt;
    logic signed [24:0] w_k1;
    logic signed [24:0] w_k2;
    logic signed [47:0] w_sum;
    logic signed [47:0] w_xn;

    // attraction distances kept in 33 bits
    assign w_d1 = $signed({i_pb[31], i_pb}) - $signed({i_x[31], i_x});
    assign w_d2 = $signed({i_gb[31], i_gb}) - $signed({i_x[31], i_x});
    assign w_w  = $signed({1'b0, i_inertia});
    assign w_dt = $signed({1'b0, i_dt});
    assign w_k1 = $signed({1'b0, i_k1});
    assign w_k2 = $signed({1'b0, i_k2});

    // stage 1: the three products
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_p_in <= 49'(i_v) * 49'(w_w);
            r_p1   <= 58'(w_d1) * 58'(w_k1);
            r_p2   <= 58'(w_d2) * 58'(w_k2);
        end
    end

    // stage 2: exact sum, saturated new velocity
    assign w_sum = 48'(r_p_in >>> 12) + 48'(r_p1 >>> 12) + 48'(r_p2 >>> 12);

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_en) begin
            r_nv <= sat32(w_sum);
        end
    end

    // stage 3: velocity times step length
    always_ff @(posedge i_clk) begin
        if (i_ctl.pos_en) begin
            r_vdt <= 49'(r_nv) * 49'(w_dt);
        end
    end

    assign w_xn = 48'(i_x) + 48'(r_vdt >>> 8);
    assign o_nv = r_nv;
    assign o_nx = sat32(w_xn);

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for particle_swarm_update: driver, monitor, predictor
// depends on psu_pkg and the particle_swarm_update design files
module tb;
    import psu_pkg::*;

    typedef struct {
        logic [1:0]         mode;
        logic [5:0]         particle;
        logic [2:0]         coord;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] fit;
        logic               eor;
        logic [15:0]        r1;
        logic [15:0]        r2;
    } t_req;

    typedef struct {
        logic               kind;
        logic [5:0]         particle;
        logic [2:0]         coord;
        logic signed [31:0] pos;
        logic signed [31:0] rmin;
        logic [5:0]         bp;
        logic               conv;
        logic               last;
    } t_res;

    logic i_clk, i_rst_n, start, busy;
    logic [1:0] i_mode;
    logic [5:0] i_particle;
    logic [2:0] i_coord_index;
    logic signed [31:0] i_position_in, i_velocity_in, i_fitness;
    logic i_end_of_round;
    logic [15:0] i_rand_one, i_rand_two;
    logic o_result_valid, o_kind, o_converged, o_last;
    logic [5:0] o_particle_out, o_best_particle;
    logic [2:0] o_coord_out;
    logic signed [31:0] o_position_out, o_round_min;
    logic psel, penable, pwrite, pready;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;

    particle_swarm_update DUT (.*);

    // swarm state mirror
    logic signed [31:0] m_pos [NUM_PARTICLES*DIMS];
    logic signed [31:0] m_vel [NUM_PARTICLES*DIMS];
    logic signed [31:0] m_pbest [NUM_PARTICLES*DIMS];
    logic signed [31:0] m_pbest_fit [NUM_PARTICLES];
    bit                 m_pbest_ok [NUM_PARTICLES];
    logic signed [31:0] m_gbest [DIMS];
    logic signed [31:0] m_rmin;
    logic [5:0]         m_rmin_idx;
    bit                 m_rmin_ok;
    logic signed [31:0] m_overall;
    bit                 m_overall_ok;
    logic [15:0] w_q, c1_q, c2_q, dt_q, idt_q;
    logic [30:0] tol_q;

    // bookkeeping for legal stimulus
    bit loaded [NUM_PARTICLES*DIMS];
    bit gbest_set;

    t_req pending_reqs[$];
    t_res expected_results[$];
    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    bit drv_active = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic logic signed [63:0] floor_shr(input logic signed [63:0] x,
                                                     input int n);
        return x >>> n;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic signed [63:0] attraction_gain(input logic [15:0] c,
                                                           input logic [15:0] r);
        logic [63:0] g;
        g = ({48'd0, c} * {48'd0, r}) >> 16;
        g = (g * {48'd0, idt_q}) >> 8;
        return $signed(g);
    endfunction

    // compute expected results of one request and advance the mirror
    task automatic predict_swarm(input t_req q);
        int a;
        logic signed [63:0] k1, k2, x, t;
        logic signed [31:0] nv, nx;
        logic signed [63:0] diff;
        bit conv;
        t_res r;
        if (q.mode == MODE_LOAD) begin
            if (q.particle < NUM_PARTICLES && q.coord < DIMS) begin
                a = q.particle * DIMS + q.coord;
                m_pos[a] = q.pos; m_vel[a] = q.vel; m_pbest[a] = q.pos;
                m_pbest_ok[q.particle] = 0;
            end
        end else if (q.mode == MODE_FITNESS) begin
            if (q.particle < NUM_PARTICLES) begin
                if (!m_pbest_ok[q.particle] || q.fit < m_pbest_fit[q.particle]) begin
                    m_pbest_fit[q.particle] = q.fit;
                    m_pbest_ok[q.particle] = 1;
                    for (int d = 0; d < DIMS; d++)
                        m_pbest[q.particle*DIMS+d] = m_pos[q.particle*DIMS+d];
                end
                if (!m_rmin_ok || q.fit < m_rmin) begin
                    m_rmin = q.fit; m_rmin_idx = q.particle; m_rmin_ok = 1;
                    for (int d = 0; d < DIMS; d++) m_gbest[d] = m_pos[q.particle*DIMS+d];
                end
            end
            if (q.eor) begin
                r = '{KIND_REPORT, 0, 0, 0, 0, 0, 0, 1};
                if (m_rmin_ok) begin
                    conv = 0;
                    if (m_overall_ok) begin
                        diff = 64'(m_overall) - 64'(m_rmin);
                        if (diff < 0) diff = -diff;
                        conv = diff < $signed({33'd0, tol_q});
                    end
                    if (!m_overall_ok || conv || m_rmin < m_overall) m_overall = m_rmin;
                    m_overall_ok = 1;
                    r.rmin = m_rmin; r.bp = m_rmin_idx; r.conv = conv;
                    m_rmin_ok = 0; m_rmin = 0; m_rmin_idx = 0;
                end
                expected_results.push_back(r);
            end
        end else if (q.mode == MODE_STEP && q.particle < NUM_PARTICLES) begin
            k1 = attraction_gain(c1_q, q.r1);
            k2 = attraction_gain(c2_q, q.r2);
            for (int d = 0; d < DIMS; d++) begin
                a = q.particle * DIMS + d;
                x = m_pos[a];
                t = floor_shr(64'(m_vel[a]) * $signed({48'd0, w_q}), 12);
                t += floor_shr((64'(m_pbest[a]) - x) * k1, 12);
                t += floor_shr((64'(m_gbest[d]) - x) * k2, 12);
                nv = clamp32(t);
                nx = clamp32(x + floor_shr(64'(nv) * $signed({48'd0, dt_q}), 8));
                m_vel[a] = nv; m_pos[a] = nx;
                if (d < NREP)
                    expected_results.push_back('{KIND_COORD, q.particle, d[2:0], nx,
                                                 0, 0, 0, (d + 1 == NREP)});
            end
        end
    endtask

    // driver: takes requests from the queue, predicts on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) predict_swarm(pending_reqs.pop_front());
            if (drv_active && pending_reqs.size() > 0
                && (start && busy || $urandom_range(99) >= send_idle_pct)) begin
                t_req q;
                q = pending_reqs[0];
                start <= 1'b1;
                i_mode <= q.mode; i_particle <= q.particle; i_coord_index <= q.coord;
                i_position_in <= q.pos; i_velocity_in <= q.vel; i_fitness <= q.fit;
                i_end_of_round <= q.eor; i_rand_one <= q.r1; i_rand_two <= q.r2;
            end else if (!(start && busy)) begin
                start <= 1'b0;
            end
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && o_result_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                t_res e;
                e = expected_results.pop_front();
                if (o_kind !== e.kind) report_mismatch($sformatf("kind %0d exp %0d", o_kind, e.kind));
                if (o_particle_out !== e.particle)
                    report_mismatch($sformatf("particle %0d exp %0d", o_particle_out, e.particle));
                if (o_coord_out !== e.coord)
                    report_mismatch($sformatf("coord %0d exp %0d", o_coord_out, e.coord));
                if (o_position_out !== e.pos)
                    report_mismatch($sformatf("position %h exp %h", o_position_out, e.pos));
                if (o_round_min !== e.rmin)
                    report_mismatch($sformatf("round_min %h exp %h", o_round_min, e.rmin));
                if (o_best_particle !== e.bp)
                    report_mismatch($sformatf("best %0d exp %0d", o_best_particle, e.bp));
                if (o_converged !== e.conv)
                    report_mismatch($sformatf("converged %0d exp %0d", o_converged, e.conv));
                if (o_last !== e.last)
                    report_mismatch($sformatf("last %0d exp %0d", o_last, e.last));
            end
        end
        if (cycles > 400000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_INERTIA:  w_q = val[15:0];
            REG_COG_GAIN: c1_q = val[15:0];
            REG_SOC_GAIN: c2_q = val[15:0];
            REG_DT:       dt_q = val[15:0];
            REG_INV_DT:   idt_q = val[15:0];
            REG_TOL:      tol_q = val[30:0];
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(0, 200000)) - 32'sd100000);
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic t_req blank_req();
        t_req q;
        q = '{MODE_LOAD, 0, 0, 0, 0, 0, 0, 0, 0};
        return q;
    endfunction

    task automatic add_load(input int p, input int d, input logic signed [31:0] x,
                            input logic signed [31:0] v);
        t_req q;
        q = blank_req();
        q.mode = MODE_LOAD; q.particle = 6'(p); q.coord = 3'(d); q.pos = x; q.vel = v;
        q.fit = $urandom; q.eor = 1'($urandom); q.r1 = 16'($urandom); q.r2 = 16'($urandom);
        pending_reqs.push_back(q);
        loaded[p*DIMS+d] = 1;
    endtask

    task automatic add_fitness(input int p, input logic signed [31:0] f, input bit eor);
        t_req q;
        q = blank_req();
        q.mode = MODE_FITNESS; q.particle = 6'(p); q.fit = f; q.eor = eor;
        q.pos = $urandom; q.vel = $urandom; q.coord = 3'($urandom);
        pending_reqs.push_back(q);
        if (p < NUM_PARTICLES) gbest_set = 1;
    endtask

    task automatic add_step(input int p, input logic [15:0] a, input logic [15:0] b);
        t_req q;
        q = blank_req();
        q.mode = MODE_STEP; q.particle = 6'(p); q.r1 = a; q.r2 = b;
        q.pos = $urandom; q.vel = $urandom; q.coord = 3'($urandom); q.fit = $urandom;
        pending_reqs.push_back(q);
    endtask

    function automatic bit row_loaded(input int p);
        for (int d = 0; d < DIMS; d++) if (!loaded[p*DIMS+d]) return 0;
        return 1;
    endfunction

    // wait for the queue and expectations to drain, plus block latency
    task automatic drain();
        while (pending_reqs.size() != 0 || start || busy || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4 + 5*DIMS + 10) @(posedge i_clk);
    endtask

    initial begin
        int p, n;
        start = 0; i_mode = 0; i_particle = 0; i_coord_index = 0;
        i_position_in = 0; i_velocity_in = 0; i_fitness = 0; i_end_of_round = 0;
        i_rand_one = 0; i_rand_two = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        w_q = 2867; c1_q = 8192; c2_q = 8192; dt_q = 256; idt_q = 256; tol_q = 0;
        m_rmin = 0; m_rmin_idx = 0; m_rmin_ok = 0; m_overall = 0; m_overall_ok = 0;
        gbest_set = 0;
        foreach (m_pbest_ok[i]) m_pbest_ok[i] = 0;
        foreach (loaded[i]) loaded[i] = 0;
        i_rst_n = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extreme loads, each mode, ignored items
        for (int d = 0; d < DIMS; d++) add_load(0, d, 32'sh7fffffff, 32'sh7fffffff);
        for (int d = 0; d < DIMS; d++) add_load(63, d, 32'sh80000000, 32'sh80000000);
        add_fitness(0, 0, 1);
        add_fitness(0, 32'sh7fffffff, 0);
        add_fitness(63, 32'sh80000000, 0);
        add_fitness(63, 32'sh80000000, 1);
        add_step(0, 16'hffff, 16'hffff);
        add_step(63, 16'h0000, 16'hffff);
        begin
            t_req q;
            q = blank_req(); q.mode = 2'd3; q.particle = 6'h3f; q.eor = 1;
            pending_reqs.push_back(q);
        end
        add_fitness(0, 32'sh80000000, 1);
        drv_active = 1;
        drain();

        // phases with different register settings and idling
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: send_idle_pct = 0;
                1: send_idle_pct = 60;
                2: send_idle_pct = 19;
                default: send_idle_pct = (ph % 2) ? 0 : 60;
            endcase
            case (ph)
                1: begin
                    write_reg(REG_INERTIA, 32'hffff); write_reg(REG_COG_GAIN, 32'hffff);
                    write_reg(REG_SOC_GAIN, 32'hffff); write_reg(REG_DT, 32'hffff);
                    write_reg(REG_INV_DT, 32'hffff); write_reg(REG_TOL, 32'hffffffff);
                end
                2: begin
                    write_reg(REG_INERTIA, 0); write_reg(REG_COG_GAIN, 0);
                    write_reg(REG_SOC_GAIN, 0); write_reg(REG_DT, 1);
                    write_reg(REG_INV_DT, 1); write_reg(REG_TOL, 0);
                end
                default: begin
                    write_reg(REG_INERTIA, $urandom_range(0, 8192));
                    write_reg(REG_COG_GAIN, $urandom_range(0, 16384));
                    write_reg(REG_SOC_GAIN, $urandom_range(0, 16384));
                    write_reg(REG_DT, $urandom_range(1, 1024));
                    write_reg(REG_INV_DT, $urandom_range(1, 1024));
                    write_reg(REG_TOL, $urandom_range(0, 1 << 20));
                    write_reg(3'd6, $urandom);
                end
            endcase
            drv_active = 0;
            // well-formed rounds: load rows, report fitness, close, step
            for (int it = 0; it < 28; it++) begin
                n = $urandom_range(99);
                p = $urandom_range(0, 7) * 9 % NUM_PARTICLES;
                if (n < 10 || !row_loaded(p)) begin
                    for (int d = 0; d < DIMS; d++)
                        if (!loaded[p*DIMS+d] || $urandom_range(3) == 0)
                            add_load(p, d, rand_word(), rand_word());
                    if ($urandom_range(3) == 0)
                        add_load(p, $urandom_range(0, 7), rand_word(), rand_word());
                end else if (n < 45) begin
                    add_fitness(p, (n < 20) ? rand_word() :
                                $signed(32'($urandom_range(0, 2000)) - 32'sd1000),
                                $urandom_range(2) == 0);
                end else if (n < 50) begin
                    add_fitness(p, rand_word(), 1);
                end else if (gbest_set) begin
                    add_step(p, 16'($urandom), 16'($urandom));
                end else begin
                    add_fitness(p, rand_word(), 0);
                end
            end
            drv_active = 1;
            drain();
        end

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// File: particle_swarm_update.f
design/psu_pkg.sv
design/psu_step_dp.sv
design/particle_swarm_update.sv
test/tb.sv
